@@ hdl/npcs_pkg.sv @@
package npcs_pkg;

	// Palette capacity and derived widths
	localparam int MAX_ENTRIES = 256;
	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = 9;
	localparam int SCAN_W = (CNT_W > ADDR_W + 1) ? CNT_W : ADDR_W + 1;
	localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

	// Field widths
	localparam int CH_W = 8;
	localparam int IDX_W = 8;
	localparam int SQ_W = 2 * CH_W;
	localparam int DIST_W = SQ_W + 2;

	// Starts above any reachable distance (3 * 255^2 fits in 18 bits)
	localparam logic [DIST_W-1:0] DIST_INIT = {DIST_W{1'b1}};

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} color_t;

	localparam int COLOR_W = $bits(color_t);

	// Classified command as it travels through the queue
	typedef struct packed {
		logic            is_query;
		logic            slot_ok;
		logic [IDX_W-1:0] slot;
		color_t          color;
	} cmd_t;

endpackage

@@ hdl/npcs_if.sv @@
interface npcs_req_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [npcs_pkg::IDX_W-1:0]  entry_index;
	logic [npcs_pkg::CH_W-1:0]   red;
	logic [npcs_pkg::CH_W-1:0]   green;
	logic [npcs_pkg::CH_W-1:0]   blue;

	modport source(output valid, command, entry_index, red, green, blue, input ready);
	modport sink(input valid, command, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [npcs_pkg::IDX_W-1:0]  best_index;

	modport source(output valid, best_index, input ready);
	modport sink(input valid, best_index, output ready);
endinterface

interface npcs_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [npcs_pkg::CNT_W-1:0]  entry_count;

	modport source(output valid, entry_count, input ready);
	modport sink(input valid, entry_count, output ready);
endinterface

@@ hdl/npcs_ram.sv @@
module npcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/npcs_front.sv @@
module npcs_front (
	input  logic            clk,
	input  logic            arst_n,
	npcs_req_if.sink        req,
	output npcs_pkg::cmd_t  q_cmd,
	output logic            q_valid,
	input  logic            q_pop
);

	npcs_pkg::cmd_t                 entries_q [npcs_pkg::QDEPTH];
	logic [npcs_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [npcs_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [npcs_pkg::QCNT_W-1:0]    cnt_q;
	npcs_pkg::cmd_t                 cmd_in;
	logic                           push;

	// Classify the incoming word
	always_comb begin
		cmd_in.is_query    = (req.command == npcs_pkg::CMD_QUERY);
		cmd_in.slot_ok     = (npcs_pkg::SCAN_W'(req.entry_index)
			< npcs_pkg::SCAN_W'(npcs_pkg::MAX_ENTRIES));
		cmd_in.slot        = req.entry_index;
		cmd_in.color.red   = req.red;
		cmd_in.color.green = req.green;
		cmd_in.color.blue  = req.blue;
	end

	assign req.ready = (cnt_q < npcs_pkg::QCNT_W'(npcs_pkg::QDEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_cmd     = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == npcs_pkg::QPTR_W'(npcs_pkg::QDEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == npcs_pkg::QPTR_W'(npcs_pkg::QDEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hdl/npcs_back.sv @@
module npcs_back (
	input  logic            clk,
	input  logic            arst_n,
	npcs_cfg_if.sink        cfg,
	input  npcs_pkg::cmd_t  q_cmd,
	input  logic            q_valid,
	output logic            q_pop,
	npcs_rsp_if.source      rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [npcs_pkg::CNT_W-1:0]      count_q;
	logic [npcs_pkg::SCAN_W-1:0]     limit_q;
	logic [npcs_pkg::SCAN_W-1:0]     scan_q;
	npcs_pkg::color_t                query_q;
	logic [npcs_pkg::DIST_W-1:0]     best_dist_q;
	logic [npcs_pkg::ADDR_W-1:0]     best_idx_q;
	logic                            rsp_valid_q;
	logic [npcs_pkg::IDX_W-1:0]      rsp_index_q;

	logic                            v_s1;
	logic [npcs_pkg::ADDR_W-1:0]     idx_s1;
	logic                            v_s2;
	logic [npcs_pkg::ADDR_W-1:0]     idx_s2;
	logic [npcs_pkg::SQ_W-1:0]       sq_r_s2;
	logic [npcs_pkg::SQ_W-1:0]       sq_g_s2;
	logic [npcs_pkg::SQ_W-1:0]       sq_b_s2;

	logic                            ram_we;
	logic                            ram_re;
	npcs_pkg::color_t                ram_rdata;
	logic [npcs_pkg::SCAN_W-1:0]     cnt_ext;
	logic [npcs_pkg::SCAN_W-1:0]     lim_next;
	logic                            scan_last;
	logic                            rsp_free;
	logic                            pipe_empty;
	logic                            start;
	logic [npcs_pkg::DIST_W-1:0]     dist_s2;
	logic [npcs_pkg::CH_W-1:0]       d_r;
	logic [npcs_pkg::CH_W-1:0]       d_g;
	logic [npcs_pkg::CH_W-1:0]       d_b;

	assign cfg.ready = 1'b1;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign ram_we    = q_pop && !q_cmd.is_query && q_cmd.slot_ok;
	assign ram_re    = (state_q == ST_SCAN);
	assign start     = q_pop && q_cmd.is_query;
	assign cnt_ext   = npcs_pkg::SCAN_W'(count_q);
	assign lim_next  = (cnt_ext > npcs_pkg::SCAN_W'(npcs_pkg::MAX_ENTRIES))
		? npcs_pkg::SCAN_W'(npcs_pkg::MAX_ENTRIES) : cnt_ext;
	assign scan_last  = (scan_q == limit_q - npcs_pkg::SCAN_W'(1));
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign pipe_empty = !v_s1 && !v_s2;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.best_index = rsp_index_q;

	npcs_ram #(
		.WIDTH(npcs_pkg::COLOR_W),
		.DEPTH(npcs_pkg::MAX_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(npcs_pkg::ADDR_W'(q_cmd.slot)),
		.wdata(q_cmd.color),
		.re   (ram_re),
		.raddr(scan_q[npcs_pkg::ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// Absolute channel differences against the entry just read
	always_comb begin
		d_r = (query_q.red >= ram_rdata.red) ? query_q.red - ram_rdata.red
			: ram_rdata.red - query_q.red;
		d_g = (query_q.green >= ram_rdata.green) ? query_q.green - ram_rdata.green
			: ram_rdata.green - query_q.green;
		d_b = (query_q.blue >= ram_rdata.blue) ? query_q.blue - ram_rdata.blue
			: ram_rdata.blue - query_q.blue;
	end

	assign dist_s2 = npcs_pkg::DIST_W'(sq_r_s2) + npcs_pkg::DIST_W'(sq_g_s2)
		+ npcs_pkg::DIST_W'(sq_b_s2);

	// Distance pipeline: read, square, then sum and compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ram_re;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= scan_q[npcs_pkg::ADDR_W-1:0];
		idx_s2  <= idx_s1;
		sq_r_s2 <= npcs_pkg::SQ_W'(d_r) * npcs_pkg::SQ_W'(d_r);
		sq_g_s2 <= npcs_pkg::SQ_W'(d_g) * npcs_pkg::SQ_W'(d_g);
		sq_b_s2 <= npcs_pkg::SQ_W'(d_b) * npcs_pkg::SQ_W'(d_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= npcs_pkg::CNT_RESET;
			limit_q     <= '0;
			scan_q      <= '0;
			query_q     <= '0;
			best_dist_q <= npcs_pkg::DIST_INIT;
			best_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_index_q <= '0;
		end else begin
			if (cfg.valid) begin
				count_q <= cfg.entry_count;
			end
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			// Strict less-than keeps the lowest index on ties
			if (start) begin
				best_dist_q <= npcs_pkg::DIST_INIT;
				best_idx_q  <= '0;
			end else if (v_s2 && (dist_s2 < best_dist_q)) begin
				best_dist_q <= dist_s2;
				best_idx_q  <= idx_s2;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						query_q <= q_cmd.color;
						limit_q <= lim_next;
						scan_q  <= '0;
						state_q <= (lim_next == '0) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (pipe_empty && rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_index_q <= npcs_pkg::IDX_W'(best_idx_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/nearest_palette_color_search.sv @@
// Nearest palette color search.
// req carries one word per command: command selects a palette write (entry_index,
// red, green, blue stored in one slot) or a query (red, green, blue searched).
// rsp returns one best_index word per query and nothing for a write; it is the
// index of the entry with the smallest squared RGB distance among entries
// 0 .. entry_count-1, lowest index on a tie, 0 when entry_count is 0.
// cfg writes entry_count (reset 256, values above the palette depth saturate);
// write it only while no command is in flight.
// Timing: a word enters a two-deep command queue in the cycle it is accepted.
// The back end takes a write from the queue while idle; a query reads the palette
// memory once per entry in the searched range (no read when entry_count is 0),
// then the square/sum pipeline drains before the result is registered.
// So the back end finishes one query before it takes the next command, and the
// single palette read port bounds query throughput.
// Reset clears the queue, the result register and sets entry_count to 256; the
// palette is not cleared, so query only entries that were written.
// When the rsp receiver stalls, the result holds in its register, the next query
// finishes its scan and waits, and req keeps filling the queue until it is full.
module nearest_palette_color_search (
	input  logic        clk,
	input  logic        arst_n,
	npcs_req_if.sink    req,
	npcs_cfg_if.sink    cfg,
	npcs_rsp_if.source  rsp
);

	npcs_pkg::cmd_t  q_cmd;
	logic            q_valid;
	logic            q_pop;

	// Front end: accept and classify words, buffer them
	npcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_cmd  (q_cmd),
		.q_valid(q_valid),
		.q_pop  (q_pop)
	);

	// Back end: palette memory, scan engine and result register
	npcs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.q_cmd  (q_cmd),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);

endmodule

@@ test/nearest_palette_color_search_tb.sv @@
module nearest_palette_color_search_tb;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 7;
	// Share of cycles in which each side idles when it may
	localparam int IDLE_PCT = 31;
	// Long stall of the result side while commands keep coming
	localparam int HOLD_CYCLES = 600;
	// Quiet cycles after the last result before a register write;
	// covers the writes still sitting in the two-deep queue
	localparam int SETTLE_CYCLES = 16;
	// Run limit, kept well above what full-depth scans on every word
	// would take
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RANDOM_PHASES = 24;
	localparam int PHASE_WORDS = 60;
	localparam int STEADY_PHASE = 4;
	localparam int PRESSURE_PHASE = 5;
	localparam int FAR_AWAY = 32'h7FFF_FFFF;
	localparam int SCRIPT_ROWS = 21;

	typedef enum logic [1:0] {ROW_COUNT, ROW_WRITE, ROW_QUERY} row_kind_t;

	// One step of the directed script. A query row with pinned set carries
	// its answer; without it the answer comes from the palette search below.
	typedef struct {
		row_kind_t                  kind;
		logic [npcs_pkg::CNT_W-1:0] count;
		logic [npcs_pkg::IDX_W-1:0] slot;
		npcs_pkg::color_t           color;
		logic                       pinned;
		logic [npcs_pkg::IDX_W-1:0] answer;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	always #(HALF_PERIOD) clk = ~clk;

	npcs_req_if req_ch ();
	npcs_cfg_if cfg_ch ();
	npcs_rsp_if rsp_ch ();

	nearest_palette_color_search DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	// Travels with each command word: a typed answer for the directed rows
	logic                       word_pinned;
	logic [npcs_pkg::IDX_W-1:0] word_answer;

	// Our own copy of the palette and the entry count, updated on each
	// accepted write and config word, and the answers still owed by the block
	npcs_pkg::color_t           palette_copy [npcs_pkg::MAX_ENTRIES];
	logic [npcs_pkg::CNT_W-1:0] count_copy = npcs_pkg::CNT_RESET;
	logic [npcs_pkg::IDX_W-1:0] pending_best [$];
	int unsigned                fault_count = 0;

	bit no_idle;
	bit hold_wanted;
	bit hold_taken;

	script_row_t script [0:SCRIPT_ROWS-1] = '{
		// Empty palette: any color answers slot 0
		'{ROW_COUNT, 9'd0,   8'd0,   24'h000000, 1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'hFFFFFF, 1'b1, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'h000000, 1'b1, 8'd0},
		// Black twice, so black-ish queries tie between slots 0 and 2
		'{ROW_WRITE, 9'd0,   8'd0,   24'h000000, 1'b0, 8'd0},
		'{ROW_WRITE, 9'd0,   8'd1,   24'hFFFFFF, 1'b0, 8'd0},
		'{ROW_WRITE, 9'd0,   8'd2,   24'h000000, 1'b0, 8'd0},
		'{ROW_WRITE, 9'd0,   8'd3,   24'h804020, 1'b0, 8'd0},
		// Top slot, outside the searched range
		'{ROW_WRITE, 9'd0,   8'd255, 24'hFF00FF, 1'b0, 8'd0},
		'{ROW_COUNT, 9'd4,   8'd0,   24'h000000, 1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'h000000, 1'b1, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'hFFFFFF, 1'b1, 8'd1},
		'{ROW_QUERY, 9'd0,   8'd0,   24'h804020, 1'b1, 8'd3},
		'{ROW_QUERY, 9'd0,   8'd0,   24'h010101, 1'b1, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'hC8643C, 1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'hFF0000, 1'b0, 8'd0},
		// One entry in use: only black is searched
		'{ROW_COUNT, 9'd1,   8'd0,   24'h000000, 1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'hFFFFFF, 1'b1, 8'd0},
		// Two whites: exact match at the lower slot wins
		'{ROW_WRITE, 9'd0,   8'd0,   24'hFFFFFF, 1'b0, 8'd0},
		'{ROW_COUNT, 9'd3,   8'd0,   24'h000000, 1'b0, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'hFFFFFF, 1'b1, 8'd0},
		'{ROW_QUERY, 9'd0,   8'd0,   24'h000000, 1'b1, 8'd2}
	};

	function automatic int gap_sq(logic [npcs_pkg::CH_W-1:0] a,
			logic [npcs_pkg::CH_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	// Scan the searched entries in order; keep the first strict minimum and
	// stop at the first exact match. Counts above the depth saturate.
	function automatic logic [npcs_pkg::IDX_W-1:0] nearest_entry(npcs_pkg::color_t probe);
		int               limit;
		int               best;
		int               best_at;
		int               gap_total;
		npcs_pkg::color_t entry;
		limit = (int'(count_copy) > npcs_pkg::MAX_ENTRIES)
			? npcs_pkg::MAX_ENTRIES : int'(count_copy);
		best = FAR_AWAY;
		best_at = 0;
		for (int i = 0; i < limit; i++) begin
			entry = palette_copy[i[npcs_pkg::ADDR_W-1:0]];
			gap_total = gap_sq(probe.red, entry.red)
				+ gap_sq(probe.green, entry.green)
				+ gap_sq(probe.blue, entry.blue);
			if (gap_total < best) begin
				best = gap_total;
				best_at = i;
				if (gap_total == 0)
					break;
			end
		end
		return best_at[npcs_pkg::IDX_W-1:0];
	endfunction

	// Favor the channel extremes, where the squares are largest
	function automatic logic [npcs_pkg::CH_W-1:0] spread_channel();
		case ($urandom_range(9))
			0, 1: return '0;
			2, 3: return '1;
			default: return npcs_pkg::CH_W'($urandom);
		endcase
	endfunction

	function automatic npcs_pkg::color_t spread_color();
		npcs_pkg::color_t c;
		c.red = spread_channel();
		c.green = spread_channel();
		c.blue = spread_channel();
		return c;
	endfunction

	// Move a channel by a few steps, clamped to its range
	function automatic logic [npcs_pkg::CH_W-1:0] nudge(logic [npcs_pkg::CH_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return npcs_pkg::CH_W'(v);
	endfunction

	// Watch all three channels at the clock edge. Config first, then results
	// (they belong to older queries), then new command words.
	always @(posedge clk) begin : watch_ports
		logic [npcs_pkg::IDX_W-1:0] oldest;
		npcs_pkg::color_t           probe;
		if (!arst_n) begin
			count_copy = npcs_pkg::CNT_RESET;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				count_copy = cfg_ch.entry_count;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_best.size() == 0) begin
					$error("best_index: expected none, actual %0d", rsp_ch.best_index);
					fault_count++;
				end else begin
					oldest = pending_best.pop_front();
					if (rsp_ch.best_index !== oldest) begin
						$error("best_index: expected %0d, actual %0d",
							oldest, rsp_ch.best_index);
						fault_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				probe.red = req_ch.red;
				probe.green = req_ch.green;
				probe.blue = req_ch.blue;
				if (req_ch.command == npcs_pkg::CMD_WRITE)
					palette_copy[req_ch.entry_index] = probe;
				else
					pending_best.push_back(word_pinned ? word_answer : nearest_entry(probe));
			end
		end
	end

	// Result side: take words at random, except during the steady phase,
	// and hold off once for a long stretch when asked
	initial begin : result_sink
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_wanted && !hold_taken) begin
				hold_taken = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one command word and return at the edge that takes it.
	// Leave valid high: the next word or settle_block decides what follows.
	task automatic offer_word(logic cmd, logic [npcs_pkg::IDX_W-1:0] slot,
			npcs_pkg::color_t color, logic pinned, logic [npcs_pkg::IDX_W-1:0] answer);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.entry_index <= slot;
		req_ch.red <= color.red;
		req_ch.green <= color.green;
		req_ch.blue <= color.blue;
		word_pinned <= pinned;
		word_answer <= answer;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Drop valid, wait for every owed answer, then let queued writes finish
	task automatic settle_block();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_best.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_entry_count(logic [npcs_pkg::CNT_W-1:0] count);
		settle_block();
		cfg_ch.valid <= 1'b1;
		cfg_ch.entry_count <= count;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// One random phase at a fixed entry count: about a third writes, the rest
	// queries, many of them on or near a color already in the searched range
	task automatic run_phase(logic [npcs_pkg::CNT_W-1:0] count, bit squeeze);
		int                         span;
		int                         pick;
		logic [npcs_pkg::IDX_W-1:0] slot;
		npcs_pkg::color_t           color;
		write_entry_count(count);
		if (squeeze)
			hold_wanted = 1'b1;
		span = (int'(count) > npcs_pkg::MAX_ENTRIES) ? npcs_pkg::MAX_ENTRIES : int'(count);
		for (int n = 0; n < PHASE_WORDS; n++) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				// Mostly rewrite a searched slot so the answers move
				if (span > 0 && pick < 22)
					slot = npcs_pkg::IDX_W'($urandom_range(span - 1));
				else
					slot = npcs_pkg::IDX_W'($urandom);
				offer_word(npcs_pkg::CMD_WRITE, slot, spread_color(), 1'b0, '0);
			end else begin
				color = spread_color();
				if (span > 0 && pick >= 70) begin
					color = palette_copy[npcs_pkg::ADDR_W'($urandom_range(span - 1))];
					if (pick >= 85) begin
						color.red = nudge(color.red);
						color.green = nudge(color.green);
						color.blue = nudge(color.blue);
					end
				end
				// entry_index is ignored on a query; drive junk there
				offer_word(npcs_pkg::CMD_QUERY, npcs_pkg::IDX_W'($urandom), color, 1'b0, '0);
			end
		end
	endtask

	initial begin : stimulus
		logic [npcs_pkg::CNT_W-1:0] count;
		req_ch.valid <= 1'b0;
		req_ch.command <= npcs_pkg::CMD_WRITE;
		req_ch.entry_index <= '0;
		req_ch.red <= '0;
		req_ch.green <= '0;
		req_ch.blue <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.entry_count <= '0;
		word_pinned <= 1'b0;
		word_answer <= '0;
		for (int i = 0; i < npcs_pkg::MAX_ENTRIES; i++)
			palette_copy[i[npcs_pkg::ADDR_W-1:0]] = '0;
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed script; a count row waits for the block to go idle
		for (int r = 0; r < SCRIPT_ROWS; r++) begin
			case (script[r].kind)
				ROW_COUNT: begin
					write_entry_count(script[r].count);
				end
				ROW_WRITE: begin
					offer_word(npcs_pkg::CMD_WRITE, script[r].slot, script[r].color,
						1'b0, '0);
				end
				default: begin
					offer_word(npcs_pkg::CMD_QUERY, npcs_pkg::IDX_W'($urandom),
						script[r].color, script[r].pinned, script[r].answer);
				end
			endcase
		end

		// Fill every slot once so that any count may be searched from here on
		write_entry_count(npcs_pkg::CNT_RESET);
		for (int s = 0; s < npcs_pkg::MAX_ENTRIES; s++)
			offer_word(npcs_pkg::CMD_WRITE, npcs_pkg::IDX_W'(s), spread_color(), 1'b0, '0);

		// Extremes first, then mostly small counts with a few wide ones
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: count = '1;
				1: count = npcs_pkg::CNT_RESET;
				2: count = '0;
				3: count = npcs_pkg::CNT_W'(1);
				PRESSURE_PHASE: count = npcs_pkg::CNT_W'(8);
				default: begin
					case ($urandom_range(19))
						0: count = '0;
						1, 2: count = npcs_pkg::CNT_W'($urandom_range(25, 511));
						default: count = npcs_pkg::CNT_W'($urandom_range(1, 24));
					endcase
				end
			endcase
			no_idle = (p == STEADY_PHASE);
			run_phase(count, p == PRESSURE_PHASE);
		end
		no_idle = 1'b0;

		settle_block();
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Bound the run in case the block stops answering
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
